[src/lksc_pkg.sv]
// Shared widths, request codes and controller/datapath handshake types for the slot cache.
package lksc_pkg;

  localparam int KEY_W  = 64;
  localparam int TIME_W = 32;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 6;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_STORE  = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic commit;
  } lksc_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_scan;
    logic scan_zero;
  } lksc_sts_t;

endpackage

[src/lksc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module lksc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/lksc_ctrl.sv]
// Request sequencer: accepts a request, runs the slot scan and commits the result.
module lksc_ctrl
  import lksc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  lksc_sts_t sts,
  output lksc_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_LAST   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Drive datapath commands
  always_comb begin
    ctl.load_req = accept;
    ctl.rd_en    = (state_r == S_SCAN);
    ctl.commit   = (state_r == S_COMMIT) && out_free;
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = sts.need_scan ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        if (sts.scan_zero) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_rose_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result appeared without a commit");

  a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN || state_r == S_COMMIT))
    else $error("accepted request did not start");

  a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && out_valid_r && out_stall) |=>
      (state_r == S_COMMIT && $stable(out_valid_r)))
    else $error("commit overran a held result");
`endif

endmodule

[src/lksc_datapath.sv]
// Slot cache datapath: key and time stores, search and victim scan, result registers.
module lksc_datapath
  import lksc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_wr_en,
  input  logic [CFG_W-1:0]                          cfg_wr_data,
  input  op_t                                       in_operation,
  input  logic [KEY_W-1:0]                          in_key,
  input  logic [TIME_W-1:0]                         in_now_ms,
  input  lksc_ctl_t                                 ctl,
  output lksc_sts_t                                 sts,
  output logic                                      out_hit,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] out_slot,
  output logic                                      out_evicted,
  output logic [KEY_W-1:0]                          out_evicted_key,
  output logic [$clog2(SLOTS + 1)-1:0]              out_occupancy
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Configuration and occupancy
  logic [CFG_W-1:0]  cap_r;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [CNT_W-1:0]  eff_lim;

  // Latched request
  op_t               req_op_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [TIME_W-1:0] req_now_r;

  // Scan state
  logic [IDX_W-1:0]  scan_idx_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  where_r;
  logic              vfound_r;
  logic [IDX_W-1:0]  victim_r;
  logic [KEY_W-1:0]  vkey_r;
  logic [TIME_W-1:0] best_r;

  // Store read data
  logic [KEY_W-1:0]  key_rdata;
  logic [TIME_W-1:0] time_rdata;

  // Commit decode
  logic              is_lookup, is_store, is_clear;
  logic              full;
  logic              do_fill, do_evict;
  logic              key_we, time_we;
  logic [IDX_W-1:0]  wr_slot;
  logic              res_hit;
  logic [IDX_W-1:0]  res_slot;

  // Result registers
  logic              out_hit_r;
  logic [IDX_W-1:0]  out_slot_r;
  logic              out_evicted_r;
  logic [KEY_W-1:0]  out_evicted_key_r;
  logic [CNT_W-1:0]  out_occupancy_r;

  logic              key_match;
  logic              time_better;

  // Clamp capacity to 1..SLOTS
  always_comb begin
    if (cap_r == '0) begin
      eff_lim = CNT_W'(1);
    end else if (32'(cap_r) > 32'(SLOTS)) begin
      eff_lim = CNT_W'(SLOTS);
    end else begin
      eff_lim = CNT_W'(cap_r);
    end
  end

  // Report scan status
  always_comb begin
    sts.need_scan = (in_operation == OP_LOOKUP || in_operation == OP_STORE) &&
                    (filled_r != '0);
    sts.scan_zero = (scan_idx_r == '0);
  end

  // Key and time stores
  lksc_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (wr_slot),
    .wr_data (req_key_r),
    .rd_en   (ctl.rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (key_rdata)
  );

  lksc_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_time_ram (
    .clk     (clk),
    .wr_en   (time_we),
    .wr_addr (wr_slot),
    .wr_data (req_now_r),
    .rd_en   (ctl.rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (time_rdata)
  );

  // Compare the slot just read
  assign key_match   = !found_r && (key_rdata == req_key_r);
  assign time_better = (time_rdata < best_r);

  // Decode the commit action
  always_comb begin
    is_lookup = (req_op_r == OP_LOOKUP);
    is_store  = (req_op_r == OP_STORE);
    is_clear  = (req_op_r == OP_CLEAR);
    full      = (filled_r >= eff_lim);
    do_fill   = is_store && !found_r && !full;
    do_evict  = is_store && !found_r && full;
    res_hit   = (is_lookup || is_store) && found_r;

    if (found_r) begin
      wr_slot = where_r;
    end else if (do_fill) begin
      wr_slot = IDX_W'(filled_r);
    end else begin
      wr_slot = victim_r;
    end

    res_slot = (is_store || res_hit) ? wr_slot : '0;
    key_we   = ctl.commit && is_store && !found_r;
    time_we  = ctl.commit && (is_store || (is_lookup && found_r));

    filled_nxt = filled_r;
    if (ctl.commit) begin
      if (is_clear) begin
        filled_nxt = '0;
      end else if (do_fill) begin
        filled_nxt = filled_r + CNT_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      filled_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      filled_r <= filled_nxt;
      rd_vld_r <= ctl.rd_en;
    end
  end

  // Latch the request and step the scan index
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_op_r   <= in_operation;
      req_key_r  <= in_key;
      req_now_r  <= in_now_ms;
      scan_idx_r <= IDX_W'(filled_r - CNT_W'(1));
    end else if (ctl.rd_en) begin
      scan_idx_r <= scan_idx_r - IDX_W'(1);
    end
    rd_idx_r <= scan_idx_r;
  end

  // Track first key match and least recent slot, scanning downward
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      found_r  <= 1'b0;
      vfound_r <= 1'b0;
      best_r   <= in_now_ms + TIME_W'(1);
    end else if (rd_vld_r) begin
      if (key_match) begin
        found_r <= 1'b1;
        where_r <= rd_idx_r;
      end
      if (time_better || (rd_idx_r == '0 && !vfound_r)) begin
        victim_r <= rd_idx_r;
        vkey_r   <= key_rdata;
      end
      if (time_better) begin
        best_r   <= time_rdata;
        vfound_r <= 1'b1;
      end
    end
  end

  // Load the result registers
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_hit_r         <= res_hit;
      out_slot_r        <= res_slot;
      out_evicted_r     <= do_evict;
      out_evicted_key_r <= do_evict ? vkey_r : '0;
      out_occupancy_r   <= filled_nxt;
    end
  end

  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;
  assign out_occupancy   = out_occupancy_r;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(SLOTS))
    else $error("occupancy above slot count");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && do_evict) |=> (filled_r == $past(filled_r)))
    else $error("eviction changed occupancy");

  a_match_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(found_r) |-> $past(rd_vld_r))
    else $error("key match without read data");
`endif

endmodule

[src/keyed_lru_slot_cache.sv]
// Top level of the keyed slot cache with least-recently-used replacement.
//
//  Port group   Direction  Handshake            Payload
//  in_*         input      in_valid / in_stall   in_operation, in_key, in_now_ms
//  out_*        output     out_valid / out_stall out_hit, out_slot, out_evicted,
//                                                out_evicted_key, out_occupancy
//  cfg_*        input      cfg_wr_en             cfg_wr_data (capacity limit)
//
// A lookup or store on a non-empty cache scans the filled slots before it commits:
// one read of the key and time stores per filled slot, highest index first,
// then the last read is compared in S_LAST and the result is written in
// S_COMMIT. Clear, unknown codes and requests on an empty cache go straight
// to commit. A new request is taken once the previous one has committed; a
// stalled result holds in the output register.
// Reset (rst_n low, synchronous) empties the cache and sets capacity to 32.
module keyed_lru_slot_cache
  import lksc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_wr_en,
  input  logic [CFG_W-1:0]                          cfg_wr_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  op_t                                       in_operation,
  input  logic [KEY_W-1:0]                          in_key,
  input  logic [TIME_W-1:0]                         in_now_ms,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic                                      out_hit,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] out_slot,
  output logic                                      out_evicted,
  output logic [KEY_W-1:0]                          out_evicted_key,
  output logic [$clog2(SLOTS + 1)-1:0]              out_occupancy
);

  lksc_ctl_t ctl;
  lksc_sts_t sts;

  lksc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  lksc_datapath #(.SLOTS(SLOTS)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_now_ms       (in_now_ms),
    .ctl             (ctl),
    .sts             (sts),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy)
  );

endmodule
